// ----- rtl/sdc_pkg.sv -----
// Shared types and constants for the scaled decimal comparator.
// No dependencies; the interfaces and the top level use this package.
`timescale 1ns / 1ps

package sdc_pkg;

  localparam int LOW_BITS        = 64;
  localparam int HIGH_BITS       = 32;
  localparam int FIELD_MANT_BITS = LOW_BITS + HIGH_BITS;
  localparam int SCALE_BITS      = 5;

  typedef struct packed {
    logic [LOW_BITS-1:0]   a_mant_low;
    logic [HIGH_BITS-1:0]  a_mant_high;
    logic [SCALE_BITS-1:0] a_scale;
    logic                  a_negative;
    logic [LOW_BITS-1:0]   b_mant_low;
    logic [HIGH_BITS-1:0]  b_mant_high;
    logic [SCALE_BITS-1:0] b_scale;
    logic                  b_negative;
  } sdc_in_t;

  typedef struct packed {
    logic less_flag;
    logic less_equal_flag;
    logic greater_flag;
    logic greater_equal_flag;
    logic equal_flag;
    logic unequal_flag;
  } sdc_out_t;

endpackage

// ----- rtl/sdc_ifs.sv -----
// Valid/ready channel interfaces for operand pairs and compare flags.
// Depends on sdc_pkg for the payload types.
`timescale 1ns / 1ps

interface sdc_in_if;
  logic            valid;
  logic            ready;
  sdc_pkg::sdc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdc_out_if;
  logic             valid;
  logic             ready;
  sdc_pkg::sdc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sdc_mul10.sv -----
// Shared multiply-by-ten unit: shift-and-add over the wide alignment word.
// Wraps modulo 2^W. No package dependency.
`timescale 1ns / 1ps

module sdc_mul10 #(
  parameter int W = 224
) (
  input  logic [W-1:0] x,
  output logic [W-1:0] y
);

  // 10x = 8x + 2x, carries beyond the top bit drop
  assign y = (x << 3) + (x << 1);

endmodule

// ----- rtl/scaled_decimal_compare.sv -----
// Scaled decimal comparator top level: sequencer, operand registers, output stage.
// Depends on sdc_pkg, sdc_ifs (sdc_in_if, sdc_out_if) and sdc_mul10.
//
// Usage:
//   in_ch carries one operand pair per item: 96-bit mantissas (low and high
//   words), a power-of-ten scale and a sign for each side. out_ch returns one
//   item of six flags (less, less-equal, greater, greater-equal, equal,
//   unequal) per operand pair. Scales above MAX_SCALE saturate to MAX_SCALE.
//   Both channels use valid/ready; an item moves when both are high.
// Timing:
//   The operand with the smaller scale is multiplied by ten once per cycle in
//   the shared sdc_mul10 unit, d = |a_scale - b_scale| times (0 to MAX_SCALE),
//   followed by a wide magnitude compare, which waits while the output register
//   is full. The block takes one item at a time: no new pair is accepted until
//   the last one has left compare; in_ch.ready is high only while the sequencer
//   is idle.
// Reset and stalls:
//   Synchronous active-low reset returns the sequencer to idle and drops
//   out_ch.valid. A stalled receiver holds the flags; the next item may be
//   accepted and aligned meanwhile, and waits in compare until the output
//   register frees up.
`timescale 1ns / 1ps

module scaled_decimal_compare #(
  parameter int MANTISSA_BITS = 96,
  parameter int MAX_SCALE     = 28,
  parameter int WIDE_BITS     = 224
) (
  input logic      clk,
  input logic      rst_n,
  sdc_in_if.sink   in_ch,
  sdc_out_if.source out_ch
);

  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int MB = sdc_pkg::FIELD_MANT_BITS;
  localparam logic [MB-1:0] MANT_MASK =
    (MANTISSA_BITS >= MB) ? {MB{1'b1}} : ((MB'(1) << MANTISSA_BITS) - MB'(1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_CMP
  } state_t;

  state_t                state_r, state_nxt;
  logic [WIDE_BITS-1:0]  a_r, a_nxt;
  logic [WIDE_BITS-1:0]  b_r, b_nxt;
  logic                  a_neg_r, a_neg_nxt;
  logic                  b_neg_r, b_neg_nxt;
  logic                  sel_b_r, sel_b_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  lt_r, lt_nxt;
  logic                  eq_r, eq_nxt;

  logic [SW-1:0]         sa, sb;
  logic [MB-1:0]         a_raw, b_raw;
  logic [WIDE_BITS-1:0]  mul_x, mul_y;
  logic                  a_zero, b_zero, mag_lt, mag_gt, mag_eq;
  logic                  out_free;
  logic                  in_take;

  sdc_mul10 #(.W(WIDE_BITS)) u_mul10 (
    .x (mul_x),
    .y (mul_y)
  );

  assign mul_x = sel_b_r ? b_r : a_r;

  assign sa = (32'(in_ch.data.a_scale) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(in_ch.data.a_scale);
  assign sb = (32'(in_ch.data.b_scale) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(in_ch.data.b_scale);

  assign a_raw = {in_ch.data.a_mant_high, in_ch.data.a_mant_low} & MANT_MASK;
  assign b_raw = {in_ch.data.b_mant_high, in_ch.data.b_mant_low} & MANT_MASK;

  assign a_zero = (a_r == '0);
  assign b_zero = (b_r == '0);
  assign mag_lt = (a_r < b_r);
  assign mag_gt = (b_r < a_r);
  assign mag_eq = (a_r == b_r);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    a_neg_nxt     = a_neg_r;
    b_neg_nxt     = b_neg_r;
    sel_b_nxt     = sel_b_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    lt_nxt        = lt_r;
    eq_nxt        = eq_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          a_nxt     = WIDE_BITS'(a_raw);
          b_nxt     = WIDE_BITS'(b_raw);
          a_neg_nxt = in_ch.data.a_negative;
          b_neg_nxt = in_ch.data.b_negative;
          // scale up whichever side has the smaller scale
          sel_b_nxt = (sb < sa);
          cnt_nxt   = (sb < sa) ? (sa - sb) : (sb - sa);
          state_nxt = (sa == sb) ? ST_CMP : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (sel_b_r) begin
          b_nxt = mul_y;
        end else begin
          a_nxt = mul_y;
        end
        cnt_nxt = cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (out_free) begin
          if (a_zero && b_zero) begin
            lt_nxt = 1'b0;
            eq_nxt = 1'b1;
          end else if (a_neg_r != b_neg_r) begin
            lt_nxt = a_neg_r;
            eq_nxt = 1'b0;
          end else begin
            // both negative: larger magnitude is the smaller value
            lt_nxt = a_neg_r ? mag_gt : mag_lt;
            eq_nxt = mag_eq;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    a_neg_r <= a_neg_nxt;
    b_neg_r <= b_neg_nxt;
    sel_b_r <= sel_b_nxt;
    cnt_r   <= cnt_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.data.less_flag          = lt_r;
  assign out_ch.data.less_equal_flag    = lt_r || eq_r;
  assign out_ch.data.greater_flag       = !lt_r && !eq_r;
  assign out_ch.data.greater_equal_flag = !lt_r;
  assign out_ch.data.equal_flag         = eq_r;
  assign out_ch.data.unequal_flag       = !eq_r;

  // a flag item never claims both less and equal
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(lt_r && eq_r))
    else $error("less and equal both set on output item");

  // alignment never runs with an exhausted step count
  a_align_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALIGN) |-> (cnt_r != '0))
    else $error("alignment step with zero count");

  // last alignment step hands over to compare
  a_align_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALIGN && cnt_r == SW'(1)) |=> (state_r == ST_CMP))
    else $error("alignment did not end in compare");

  // compare with a free output stage produces a result next cycle
  a_cmp_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("compare did not deliver a result");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(lt_r) && $stable(eq_r)))
    else $error("pending result lost");

endmodule
